@@ rtl/touch_sample_filter_and_scale_core_macros.svh @@
// ----------------------------------------------------------------------------
// Touch sample filter: assertion macros
// Shared concurrent assertion forms, clocked on clock, reset active high.
// ----------------------------------------------------------------------------
`ifndef TOUCH_SAMPLE_FILTER_AND_SCALE_CORE_MACROS_SVH
`define TOUCH_SAMPLE_FILTER_AND_SCALE_CORE_MACROS_SVH

// Checked only outside reset.
`define TSFS_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Checked on every edge, reset included.
`define TSFS_ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);

`endif

@@ rtl/tsfs_pkg.sv @@
// ----------------------------------------------------------------------------
// Touch sample filter: package
// Widths, field positions, codes and the divide-by-constant reciprocal.
// ----------------------------------------------------------------------------
package tsfs_pkg;

   // group sizing
   localparam int SAMPLES_PER_READ = 5;
   localparam int TRIM_DIV         = SAMPLES_PER_READ - 2;
   localparam int SAMPLE_IDX_W     = $clog2(SAMPLES_PER_READ);

   // converter word
   localparam int REQ_DATA_W = 16;
   localparam int READ_LSB   = 3;
   localparam int READ_W     = 12;
   localparam int SUM_W      = 16;

   // trimmed mean: floor(x / TRIM_DIV) == (x * DIV_MULT) >> DIV_SHIFT for any SUM_W-bit x
   localparam int DIV_SHIFT  = SUM_W + $clog2(TRIM_DIV);
   localparam int DIV_MULT_W = SUM_W + 1;
   localparam int DIV_PROD_W = SUM_W + DIV_MULT_W;
   localparam logic [DIV_MULT_W-1:0] DIV_MULT =
      DIV_MULT_W'(((64'd1 << DIV_SHIFT) + 64'(TRIM_DIV) - 64'd1) / 64'(TRIM_DIV));

   // scaling
   localparam int GAIN_W    = 24;
   localparam int FRAC_BITS = 16;
   localparam int OFFS_W    = 16;
   localparam int COORD_W   = 16;
   localparam int SCALED_W  = READ_W + GAIN_W - FRAC_BITS;
   localparam int WIN_W     = 2 * READ_W;
   localparam int SCREEN_W  = 2 * COORD_W;

   // result beat
   localparam int STATUS_W     = 2;
   localparam int RAW_X_LSB    = 0;
   localparam int RAW_Y_LSB    = RAW_X_LSB + READ_W;
   localparam int SCREEN_X_LSB = RAW_Y_LSB + READ_W;
   localparam int SCREEN_Y_LSB = SCREEN_X_LSB + COORD_W;
   localparam int RSP_DATA_W   = SCREEN_Y_LSB + COORD_W;

   // register port
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 32;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_JITTER   = 3'd0,
      CSR_X_WINDOW = 3'd1,
      CSR_Y_WINDOW = 3'd2,
      CSR_X_GAIN   = 3'd3,
      CSR_X_OFFSET = 3'd4,
      CSR_Y_GAIN   = 3'd5,
      CSR_Y_OFFSET = 3'd6,
      CSR_SCREEN   = 3'd7
   } csr_index_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK       = 2'd0,
      ST_UNSTEADY = 2'd1,
      ST_WINDOW   = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      GRP_X1 = 2'd0,
      GRP_Y1 = 2'd1,
      GRP_X2 = 2'd2,
      GRP_Y2 = 2'd3
   } grp_type;

endpackage

@@ rtl/touch_sample_filter_and_scale_core.sv @@
// ----------------------------------------------------------------------------
// Touch sample filter and scaler
// Trimmed-mean filtering of converter reads, jitter and window checks,
// and fixed-point scaling to screen pixels.
// ----------------------------------------------------------------------------
//
//  channel | dir | beat contents (lowest bit first)
//  --------+-----+-------------------------------------------------------
//  req_    | in  | tdata: raw_word[15:0]
//  rsp_    | out | tdata: raw_x, raw_y, screen_x, screen_y; tuser: status
//  csr_    | in  | csr_index selects register, csr_wdata, write on csr_wen
//
//  One req beat is taken per cycle, but the beat that closes the fourth group of a
//  frame waits until the result pipeline (4 stages) and the output register are
//  empty; its result then passes through stages A, B, C and D into the output
//  register. A waiting rsp beat holds up only the closing beat of the next frame.
//  Synchronous reset restores register defaults and empties the pipeline.
//
module touch_sample_filter_and_scale_core (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   input  logic [tsfs_pkg::REQ_DATA_W-1:0]  req_tdata,   // raw_word
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   output logic [tsfs_pkg::RSP_DATA_W-1:0]  rsp_tdata,   // raw_x, raw_y, screen_x, screen_y
   output logic [tsfs_pkg::STATUS_W-1:0]    rsp_tuser,   // status
   input  logic                             csr_wen,
   input  logic [tsfs_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [tsfs_pkg::CSR_DATA_W-1:0]  csr_wdata
);
   import tsfs_pkg::*;

   localparam int CLAMP_W = SCALED_W + 2;

   // ------------------------------------------------------------------
   // configuration registers
   // ------------------------------------------------------------------
   logic [READ_W-1:0]   jitter_ff;
   logic [WIN_W-1:0]    x_window_ff, y_window_ff;
   logic [GAIN_W-1:0]   x_gain_ff, y_gain_ff;
   logic [OFFS_W-1:0]   x_offset_ff, y_offset_ff;
   logic [SCREEN_W-1:0] screen_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         jitter_ff   <= '1;
         x_window_ff <= {{READ_W{1'b1}}, {READ_W{1'b0}}};
         y_window_ff <= {{READ_W{1'b1}}, {READ_W{1'b0}}};
         x_gain_ff   <= GAIN_W'(1) << FRAC_BITS;
         y_gain_ff   <= GAIN_W'(1) << FRAC_BITS;
         x_offset_ff <= '0;
         y_offset_ff <= '0;
         screen_ff   <= '1;
      end else if (csr_wen) begin
         unique case (csr_index_type'(csr_index))
            CSR_JITTER:   jitter_ff   <= csr_wdata[READ_W-1:0];
            CSR_X_WINDOW: x_window_ff <= csr_wdata[WIN_W-1:0];
            CSR_Y_WINDOW: y_window_ff <= csr_wdata[WIN_W-1:0];
            CSR_X_GAIN:   x_gain_ff   <= csr_wdata[GAIN_W-1:0];
            CSR_X_OFFSET: x_offset_ff <= csr_wdata[OFFS_W-1:0];
            CSR_Y_GAIN:   y_gain_ff   <= csr_wdata[GAIN_W-1:0];
            CSR_Y_OFFSET: y_offset_ff <= csr_wdata[OFFS_W-1:0];
            CSR_SCREEN:   screen_ff   <= csr_wdata[SCREEN_W-1:0];
         endcase
      end
   end

   // ------------------------------------------------------------------
   // group sequencing and running sum / max / min
   // ------------------------------------------------------------------
   logic [SAMPLE_IDX_W-1:0] cnt_ff;
   logic [SUM_W-1:0]        sum_ff;
   logic [READ_W-1:0]       max_ff, min_ff;
   grp_type                 grp_ff, grp_in;

   logic              last_sample, grp_final, frame_close, busy, req_fire;
   logic [READ_W-1:0] v, max_upd, min_upd;
   logic [SUM_W-1:0]  sum_upd, trimmed;

   // stage A: trimmed total of a finished group
   logic             vld_a_ff;
   grp_type          grp_a_ff;
   logic [SUM_W-1:0] tot_a_ff;
   // stage B: divided means
   logic              fin_b_ff;
   logic [READ_W-1:0] fx_ff, fy_ff, sx_ff, sy_ff;
   // stage C: checks and axis averages
   logic              fin_c_ff;
   status_type        st_c_ff;
   logic [READ_W-1:0] ax_c_ff, ay_c_ff;
   // stage D: scaled values
   logic                fin_d_ff;
   status_type          st_d_ff;
   logic [READ_W-1:0]   ax_d_ff, ay_d_ff;
   logic [SCALED_W-1:0] px_d_ff, py_d_ff;
   // output register
   logic                  rsp_vld_ff;
   logic [RSP_DATA_W-1:0] rsp_data_ff;
   status_type            rsp_st_ff;

   assign last_sample = (cnt_ff == SAMPLE_IDX_W'(SAMPLES_PER_READ - 1));

   // group sequencer: next state
   always_comb begin
      grp_in = grp_ff;
      if (req_fire && last_sample) begin
         unique case (grp_ff)
            GRP_X1: grp_in = GRP_Y1;
            GRP_Y1: grp_in = GRP_X2;
            GRP_X2: grp_in = GRP_Y2;
            GRP_Y2: grp_in = GRP_X1;
         endcase
      end
   end

   // group sequencer: outputs
   always_comb begin
      grp_final = (grp_ff == GRP_Y2);
   end

   // The closing beat of a frame needs the result path to itself.
   assign frame_close = last_sample && grp_final;
   assign busy = (vld_a_ff && grp_a_ff == GRP_Y2) || fin_b_ff || fin_c_ff || fin_d_ff
               || rsp_vld_ff;
   assign req_tready = !(frame_close && busy);
   assign req_fire   = req_tvalid && req_tready;

   assign v       = req_tdata[READ_LSB +: READ_W];   // bits 15 and 2:0 ignored
   assign sum_upd = sum_ff + SUM_W'(v);
   assign max_upd = (v > max_ff) ? v : max_ff;
   assign min_upd = (v < min_ff) ? v : min_ff;
   assign trimmed = sum_upd - SUM_W'(max_upd) - SUM_W'(min_upd);

   always_ff @(posedge clock) begin
      if (reset) begin
         grp_ff   <= GRP_X1;
         cnt_ff   <= '0;
         sum_ff   <= '0;
         max_ff   <= '0;
         min_ff   <= '1;
         vld_a_ff <= 1'b0;
      end else begin
         grp_ff   <= grp_in;
         vld_a_ff <= req_fire && last_sample;
         if (req_fire) begin
            if (last_sample) begin
               cnt_ff <= '0;
               sum_ff <= '0;
               max_ff <= '0;
               min_ff <= '1;
            end else begin
               cnt_ff <= cnt_ff + SAMPLE_IDX_W'(1);
               sum_ff <= sum_upd;
               max_ff <= max_upd;
               min_ff <= min_upd;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire && last_sample) begin
         tot_a_ff <= trimmed;
         grp_a_ff <= grp_ff;
      end
   end

   // ------------------------------------------------------------------
   // stage B: divide by SAMPLES_PER_READ-2 via reciprocal multiply
   // ------------------------------------------------------------------
   logic [DIV_PROD_W-1:0] div_prod;
   logic [READ_W-1:0]     mean;

   assign div_prod = DIV_PROD_W'(tot_a_ff) * DIV_PROD_W'(DIV_MULT);
   assign mean     = div_prod[DIV_SHIFT +: READ_W];

   always_ff @(posedge clock) begin
      if (reset) begin
         fin_b_ff <= 1'b0;
      end else begin
         fin_b_ff <= vld_a_ff && (grp_a_ff == GRP_Y2);
      end
   end

   always_ff @(posedge clock) begin
      if (vld_a_ff) begin
         unique case (grp_a_ff)
            GRP_X1: fx_ff <= mean;
            GRP_Y1: fy_ff <= mean;
            GRP_X2: sx_ff <= mean;
            GRP_Y2: sy_ff <= mean;
         endcase
      end
   end

   // ------------------------------------------------------------------
   // stage C: averages, jitter and window checks
   // ------------------------------------------------------------------
   logic [READ_W:0]   sum_x, sum_y;
   logic [READ_W-1:0] diff_x, diff_y, ax, ay;
   logic              unsteady, out_x, out_y;
   status_type        st_c;

   assign sum_x  = {1'b0, fx_ff} + {1'b0, sx_ff};
   assign sum_y  = {1'b0, fy_ff} + {1'b0, sy_ff};
   assign ax     = sum_x[READ_W:1];
   assign ay     = sum_y[READ_W:1];
   assign diff_x = (fx_ff > sx_ff) ? fx_ff - sx_ff : sx_ff - fx_ff;
   assign diff_y = (fy_ff > sy_ff) ? fy_ff - sy_ff : sy_ff - fy_ff;
   assign unsteady = (diff_x > jitter_ff) || (diff_y > jitter_ff);
   // inverted window rejects everything
   assign out_x = (ax < x_window_ff[READ_W-1:0]) || (ax > x_window_ff[WIN_W-1:READ_W]);
   assign out_y = (ay < y_window_ff[READ_W-1:0]) || (ay > y_window_ff[WIN_W-1:READ_W]);

   always_comb begin
      if (unsteady) begin
         st_c = ST_UNSTEADY;    // wins over a window miss
      end else if (out_x || out_y) begin
         st_c = ST_WINDOW;
      end else begin
         st_c = ST_OK;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fin_c_ff <= 1'b0;
      end else begin
         fin_c_ff <= fin_b_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (fin_b_ff) begin
         st_c_ff <= st_c;
         ax_c_ff <= ax;
         ay_c_ff <= ay;
      end
   end

   // ------------------------------------------------------------------
   // stage D: gain multiply, drop fraction bits
   // ------------------------------------------------------------------
   logic [READ_W+GAIN_W-1:0] prod_x, prod_y;

   assign prod_x = (READ_W+GAIN_W)'(ax_c_ff) * (READ_W+GAIN_W)'(x_gain_ff);
   assign prod_y = (READ_W+GAIN_W)'(ay_c_ff) * (READ_W+GAIN_W)'(y_gain_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         fin_d_ff <= 1'b0;
      end else begin
         fin_d_ff <= fin_c_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (fin_c_ff) begin
         st_d_ff <= st_c_ff;
         ax_d_ff <= ax_c_ff;
         ay_d_ff <= ay_c_ff;
         px_d_ff <= prod_x[FRAC_BITS +: SCALED_W];
         py_d_ff <= prod_y[FRAC_BITS +: SCALED_W];
      end
   end

   // ------------------------------------------------------------------
   // output register: offset, clamp to 0..limit, zero on error
   // ------------------------------------------------------------------
   function automatic logic [COORD_W-1:0] scale_clamp(
      input logic [SCALED_W-1:0] scaled,
      input logic [OFFS_W-1:0]   offs,
      input logic [COORD_W-1:0]  limit
   );
      logic signed [CLAMP_W-1:0] s;
      logic signed [CLAMP_W-1:0] lim;
      s   = signed'({2'b00, scaled}) + CLAMP_W'(signed'(offs));
      lim = signed'({{(CLAMP_W-COORD_W){1'b0}}, limit});
      if (s < 0) begin
         return '0;
      end else if (s > lim) begin
         return limit;
      end else begin
         return s[COORD_W-1:0];
      end
   endfunction

   logic [COORD_W-1:0] scr_x, scr_y;

   assign scr_x = (st_d_ff == ST_OK)
                ? scale_clamp(px_d_ff, x_offset_ff, screen_ff[COORD_W-1:0]) : '0;
   assign scr_y = (st_d_ff == ST_OK)
                ? scale_clamp(py_d_ff, y_offset_ff, screen_ff[SCREEN_W-1:COORD_W]) : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_vld_ff <= 1'b0;
      end else if (fin_d_ff) begin
         rsp_vld_ff <= 1'b1;   // output register is known empty here
      end else if (rsp_tready) begin
         rsp_vld_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (fin_d_ff) begin
         rsp_st_ff   <= st_d_ff;
         rsp_data_ff <= {scr_y, scr_x, ay_d_ff, ax_d_ff};
      end
   end

   assign rsp_tvalid = rsp_vld_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_st_ff;

endmodule

@@ rtl/tsfs_checker.sv @@
// ----------------------------------------------------------------------------
// Touch sample filter: port checker
// Watches the result channel of the core; bound to the top level below.
// ----------------------------------------------------------------------------
`include "touch_sample_filter_and_scale_core_macros.svh"

module tsfs_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            rsp_tvalid,
   input logic                            rsp_tready,
   input logic [tsfs_pkg::RSP_DATA_W-1:0] rsp_tdata,   // raw_x, raw_y, screen_x, screen_y
   input logic [tsfs_pkg::STATUS_W-1:0]   rsp_tuser    // status
);
   import tsfs_pkg::*;

   // stalled beat holds
   `TSFS_ASSERT(a_rsp_hold, rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser), "rsp beat changed while stalled")

   // error results carry no screen coordinates
   `TSFS_ASSERT(a_err_screen_zero, rsp_tvalid && rsp_tuser != ST_OK |-> rsp_tdata[RSP_DATA_W-1:SCREEN_X_LSB] == '0, "screen fields nonzero on error")

   // only defined status codes
   `TSFS_ASSERT(a_status_code, rsp_tvalid |-> rsp_tuser == ST_OK || rsp_tuser == ST_UNSTEADY || rsp_tuser == ST_WINDOW, "undefined status code")

   // a frame needs many beats, so results never follow one another directly
   `TSFS_ASSERT(a_no_repeat, rsp_tvalid && rsp_tready |=> !rsp_tvalid, "result repeated")

   // reset empties the output
   `TSFS_ASSERT_ALWAYS(a_reset_empty, reset |=> !rsp_tvalid, "result valid after reset")

endmodule

bind touch_sample_filter_and_scale_core tsfs_checker u_tsfs_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);
